// ----- rtl/akf_pkg.sv -----
// Shared types and constants for the angle/gyro-bias Kalman filter.
package akf_pkg;

   // Configuration registers: 31-bit unsigned, Q1.30
   localparam int unsigned REG_WIDTH       = 31;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_NOISE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIAS_NOISE    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASURE_NOISE = 2'd3;

   localparam logic [REG_WIDTH-1:0] RST_SAMPLE_PERIOD = 31'd1073742;
   localparam logic [REG_WIDTH-1:0] RST_ANGLE_NOISE   = 31'd1073742;
   localparam logic [REG_WIDTH-1:0] RST_BIAS_NOISE    = 31'd3221225;
   localparam logic [REG_WIDTH-1:0] RST_MEASURE_NOISE = 31'd536870912;

   typedef logic [3:0] op_type;

   // Filter micro-operations, in execution order
   localparam op_type OP_PRED_ANGLE = 4'd0;
   localparam op_type OP_PRED_CROSS = 4'd1;
   localparam op_type OP_PRED_AA    = 4'd2;
   localparam op_type OP_PRED_BB    = 4'd3;
   localparam op_type OP_GAIN0      = 4'd4;
   localparam op_type OP_GAIN1      = 4'd5;
   localparam op_type OP_UPD_ANGLE  = 4'd6;
   localparam op_type OP_UPD_BIAS   = 4'd7;
   localparam op_type OP_UPD_AA     = 4'd8;
   localparam op_type OP_UPD_AB     = 4'd9;
   localparam op_type OP_UPD_BA     = 4'd10;
   localparam op_type OP_UPD_BB     = 4'd11;
   localparam op_type OP_LAST       = OP_UPD_BB;

   typedef struct packed {
      logic   capture;
      logic   start;
      logic   wb;
      logic   load_out;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic done;
   } status_type;

endpackage

// ----- rtl/akf_mul.sv -----
// Sequential signed multiplier with round-to-nearest and fraction shift.
module akf_mul #(
   parameter int unsigned A_WIDTH = 48,
   parameter int unsigned B_WIDTH = 33,
   parameter int unsigned FRAC    = 30
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [A_WIDTH-1:0]  a,
   input  logic signed [B_WIDTH-1:0]  b,
   output logic                       done,
   output logic signed [A_WIDTH-1:0]  result
);
   localparam int unsigned NB = (B_WIDTH + 15) / 16;
   localparam int unsigned BW = 16 * NB;
   localparam int unsigned PW = A_WIDTH + BW;
   localparam int unsigned CW = $clog2(NB + 1);
   localparam logic [PW:0] RND_ONE = (PW + 1)'(1) << (FRAC - 1);
   localparam logic [A_WIDTH-1:0] MAG_MAX = {1'b0, {(A_WIDTH - 1){1'b1}}};

   logic                busy_ff, busy_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [PW-1:0]       acc_ff, acc_in;
   logic [A_WIDTH-1:0]  ma_ff, ma_in;
   logic [BW-1:0]       mb_ff, mb_in;
   logic                neg_ff, neg_in;
   logic                done_ff, done_in;
   logic signed [A_WIDTH-1:0] res_ff, res_in;

   logic [A_WIDTH-1:0]  mag_a;
   logic [B_WIDTH-1:0]  mag_b;
   logic [A_WIDTH+15:0] pp;
   logic [PW-1:0]       acc_step;
   logic [PW:0]         rnd;
   logic [PW:0]         q;
   logic [A_WIDTH-1:0]  mag_c;

   // Operand magnitudes
   assign mag_a = a[A_WIDTH-1] ? (~a + 1'b1) : a;
   assign mag_b = b[B_WIDTH-1] ? (~b + 1'b1) : b;

   // One 16-bit digit of b per cycle, most significant first
   assign pp       = (A_WIDTH + 16)'(ma_ff) * (A_WIDTH + 16)'(mb_ff[BW-1 -: 16]);
   assign acc_step = {acc_ff[PW-17:0], 16'b0} + PW'(pp);

   // Round, drop fraction, clamp magnitude
   assign rnd   = (PW + 1)'(acc_ff) + RND_ONE;
   assign q     = rnd >> FRAC;
   assign mag_c = (|q[PW:A_WIDTH-1]) ? MAG_MAX : q[A_WIDTH-1:0];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         ma_in   = mag_a;
         mb_in   = BW'(mag_b);
         neg_in  = a[A_WIDTH-1] ^ b[B_WIDTH-1];
      end else if (busy_ff) begin
         if (cnt_ff == CW'(NB)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -$signed(mag_c) : $signed(mag_c);
         end else begin
            acc_in = acc_step;
            mb_in  = {mb_ff[BW-17:0], 16'b0};
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ----- rtl/akf_div.sv -----
// Restoring divider: round((num * 2^F) / den), saturated to the data range.
module akf_div #(
   parameter int unsigned W  = 32,
   parameter int unsigned F  = 30,
   parameter int unsigned SW = 33
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [W-1:0]  num,
   input  logic signed [SW-1:0] den,
   output logic                 done,
   output logic signed [W-1:0]  quot
);
   localparam int unsigned NBITS = W + F + 1;
   localparam int unsigned CW    = $clog2(NBITS + 1);
   localparam int unsigned QW    = W + 1;
   localparam logic [QW-1:0]   LIM    = QW'(1) << (W - 1);
   localparam logic [W-1:0]    SMAX_W = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0]    SMIN_W = {1'b1, {(W - 1){1'b0}}};

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]    nsh_ff, nsh_in;
   logic [SW-2:0]   den_ff, den_in;
   logic [SW-2:0]   rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            over_ff, over_in;
   logic            neg_ff, neg_in;
   logic [W-1:0]    quot_ff, quot_in;

   logic [W-1:0]    mag_n;
   logic [SW-1:0]   rem2;
   logic [SW-1:0]   den_x;
   logic            ge;
   logic [QW:0]     qp1;
   logic [QW-1:0]   mag_q;
   logic            big;

   assign mag_n = num[W-1] ? (~num + 1'b1) : num;

   // One quotient bit per cycle
   assign rem2  = {rem_ff, nsh_ff[W-1]};
   assign den_x = {1'b0, den_ff};
   assign ge    = rem2 >= den_x;

   // Final rounding from the extra quotient bit
   assign qp1   = (QW + 1)'(q_ff) + 1'b1;
   assign mag_q = qp1[QW:1];
   assign big   = over_ff || (mag_q > LIM);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      nsh_in  = nsh_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      over_in = over_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         nsh_in  = mag_n;
         den_in  = den[SW-2:0];
         rem_in  = '0;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = num[W-1];
      end else if (busy_ff) begin
         if (cnt_ff == CW'(NBITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               quot_in = (big || mag_q >= LIM) ? SMAX_W : mag_q[W-1:0];
            end else begin
               quot_in = big ? SMIN_W : (~mag_q[W-1:0] + 1'b1);
            end
         end else begin
            rem_in  = ge ? (SW - 1)'(rem2 - den_x) : rem2[SW-2:0];
            q_in    = {q_ff[QW-2:0], ge};
            over_in = over_ff | q_ff[QW-1];
            nsh_in  = {nsh_ff[W-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nsh_ff  <= nsh_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = $signed(quot_ff);

endmodule

// ----- rtl/akf_datapath.sv -----
// Filter state, configuration registers and the shared arithmetic units.
module akf_datapath #(
   parameter int unsigned W = 32,
   parameter int unsigned F = 30
) (
   input  logic                              clock,
   input  logic                              reset,
   input  akf_pkg::cmd_type                  cmd,
   output akf_pkg::status_type               status,
   input  logic signed [W-1:0]               req_angle_meas,
   input  logic signed [W-1:0]               req_gyro_rate,
   input  logic                              csr_write_enable,
   input  logic [akf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [akf_pkg::REG_WIDTH-1:0]     csr_write_data,
   output logic signed [W-1:0]               rsp_angle_estimate
);
   import akf_pkg::*;

   localparam int unsigned WB = (W > 32) ? W : 32;
   localparam int unsigned X  = WB + 16;
   localparam int unsigned SX = X + 2;
   localparam int unsigned SW = WB + 1;
   localparam int unsigned MB = (W + 1 > 32) ? W + 1 : 32;
   localparam logic [W-1:0] SMAX_W = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] SMIN_W = {1'b1, {(W - 1){1'b0}}};
   localparam logic [W-1:0] COV_ONE = (F <= W - 2) ? (W'(1) << F) : SMAX_W;

   function automatic logic signed [W-1:0] sat_w(input logic signed [SX-1:0] v);
      logic [SX-W:0] top;
      top = v[SX-1:W-1];
      if (top == '0 || top == '1) return v[W-1:0];
      else if (v[SX-1])          return SMIN_W;
      else                       return SMAX_W;
   endfunction

   // Configuration
   logic [REG_WIDTH-1:0] dt_ff, dt_in, qa_ff, qa_in, qb_ff, qb_in, r_ff, r_in;

   // Filter state
   logic signed [W-1:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [W-1:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;

   // Per-item working registers
   logic signed [W-1:0] meas_ff, meas_in, rate_ff, rate_in;
   logic signed [X-1:0] t_ff, t_in;
   logic signed [W:0]   err_ff, err_in;
   logic signed [W-1:0] p00_ff, p00_in, p01_ff, p01_in;
   logic signed [W-1:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [W-1:0] out_ff, out_in;

   logic                is_div, mul_done, div_done, s_pos;
   logic signed [X-1:0] mul_a, mul_res;
   logic signed [MB-1:0] mul_b;
   logic signed [W-1:0] div_num, div_q;
   logic signed [SX-1:0] s_x, m_x, t_x, err_x;
   logic signed [X-1:0] dt_a, qb_a;
   logic signed [MB-1:0] dt_b;

   assign dt_a = X'({1'b0, dt_ff});
   assign qb_a = X'({1'b0, qb_ff});
   assign dt_b = MB'({1'b0, dt_ff});

   // Innovation and gain selection
   assign s_x   = SX'(aa_ff) + SX'({1'b0, r_ff});
   assign s_pos = !s_x[SX-1] && (s_x != '0);
   assign is_div = (cmd.op == OP_GAIN0) || (cmd.op == OP_GAIN1);
   assign div_num = (cmd.op == OP_GAIN1) ? ba_ff : aa_ff;

   // Multiplier operands per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_PRED_ANGLE: begin mul_a = dt_a;        mul_b = MB'(rate_ff); end
         OP_PRED_CROSS: begin mul_a = dt_a;        mul_b = MB'(bb_ff);   end
         OP_PRED_AA:    begin mul_a = t_ff;        mul_b = dt_b;         end
         OP_PRED_BB:    begin mul_a = qb_a;        mul_b = dt_b;         end
         OP_UPD_ANGLE:  begin mul_a = X'(err_ff);  mul_b = MB'(k0_ff);   end
         OP_UPD_BIAS:   begin mul_a = X'(err_ff);  mul_b = MB'(k1_ff);   end
         OP_UPD_AA:     begin mul_a = X'(p00_ff);  mul_b = MB'(k0_ff);   end
         OP_UPD_AB:     begin mul_a = X'(p01_ff);  mul_b = MB'(k0_ff);   end
         OP_UPD_BA:     begin mul_a = X'(p00_ff);  mul_b = MB'(k1_ff);   end
         OP_UPD_BB:     begin mul_a = X'(p01_ff);  mul_b = MB'(k1_ff);   end
         default:       begin mul_a = '0;          mul_b = '0;           end
      endcase
   end

   akf_mul #(.A_WIDTH(X), .B_WIDTH(MB), .FRAC(F)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start && !is_div),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   akf_div #(.W(W), .F(F), .SW(SW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && is_div),
      .num   (div_num),
      .den   (s_x[SW-1:0]),
      .done  (div_done),
      .quot  (div_q)
   );

   assign status.done = mul_done || div_done;

   assign m_x   = SX'(mul_res);
   assign t_x   = m_x - SX'(ab_ff) - SX'(ba_ff) + SX'({1'b0, qa_ff});
   assign err_x = SX'(meas_ff) - SX'(angle_ff);

   // Next state: capture, step writeback, configuration, result load
   always_comb begin
      dt_in    = dt_ff;
      qa_in    = qa_ff;
      qb_in    = qb_ff;
      r_in     = r_ff;
      angle_in = angle_ff;
      bias_in  = bias_ff;
      aa_in    = aa_ff;
      ab_in    = ab_ff;
      ba_in    = ba_ff;
      bb_in    = bb_ff;
      meas_in  = meas_ff;
      rate_in  = rate_ff;
      t_in     = t_ff;
      err_in   = err_ff;
      p00_in   = p00_ff;
      p01_in   = p01_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      out_in   = out_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD: dt_in = csr_write_data;
            CSR_ANGLE_NOISE:   qa_in = csr_write_data;
            CSR_BIAS_NOISE:    qb_in = csr_write_data;
            CSR_MEASURE_NOISE: r_in  = csr_write_data;
         endcase
      end

      if (cmd.capture) begin
         meas_in = req_angle_meas;
         rate_in = sat_w(SX'(req_gyro_rate) - SX'(bias_ff));
      end

      if (cmd.wb) begin
         unique case (cmd.op)
            OP_PRED_ANGLE: angle_in = sat_w(SX'(angle_ff) + m_x);
            OP_PRED_CROSS: begin
               t_in  = t_x[X-1:0];
               ab_in = sat_w(SX'(ab_ff) - m_x);
               ba_in = sat_w(SX'(ba_ff) - m_x);
            end
            OP_PRED_AA:    aa_in = sat_w(SX'(aa_ff) + m_x);
            OP_PRED_BB:    bb_in = sat_w(SX'(bb_ff) + m_x);
            OP_GAIN0: begin
               k0_in  = s_pos ? div_q : '0;
               err_in = err_x[W:0];
               p00_in = aa_ff;
               p01_in = ab_ff;
            end
            OP_GAIN1:      k1_in = s_pos ? div_q : '0;
            OP_UPD_ANGLE:  angle_in = sat_w(SX'(angle_ff) + m_x);
            OP_UPD_BIAS:   bias_in  = sat_w(SX'(bias_ff) + m_x);
            OP_UPD_AA:     aa_in = sat_w(SX'(aa_ff) - m_x);
            OP_UPD_AB:     ab_in = sat_w(SX'(ab_ff) - m_x);
            OP_UPD_BA:     ba_in = sat_w(SX'(ba_ff) - m_x);
            OP_UPD_BB:     bb_in = sat_w(SX'(bb_ff) - m_x);
            default:       angle_in = angle_ff;
         endcase
      end

      if (cmd.load_out) begin
         out_in = angle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff    <= RST_SAMPLE_PERIOD;
         qa_ff    <= RST_ANGLE_NOISE;
         qb_ff    <= RST_BIAS_NOISE;
         r_ff     <= RST_MEASURE_NOISE;
         angle_ff <= '0;
         bias_ff  <= '0;
         aa_ff    <= COV_ONE;
         ab_ff    <= '0;
         ba_ff    <= '0;
         bb_ff    <= COV_ONE;
      end else begin
         dt_ff    <= dt_in;
         qa_ff    <= qa_in;
         qb_ff    <= qb_in;
         r_ff     <= r_in;
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         aa_ff    <= aa_in;
         ab_ff    <= ab_in;
         ba_ff    <= ba_in;
         bb_ff    <= bb_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff <= meas_in;
      rate_ff <= rate_in;
      t_ff    <= t_in;
      err_ff  <= err_in;
      p00_ff  <= p00_in;
      p01_ff  <= p01_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      out_ff  <= out_in;
   end

   assign rsp_angle_estimate = out_ff;

`ifndef ASSERT_OFF
   // Only one arithmetic unit finishes at a time
   a_one_unit_done: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");
`endif

endmodule

// ----- rtl/akf_ctrl.sv -----
// Sequencer for the predict and update steps, plus the result handshake.
module akf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  akf_pkg::status_type status,
   output akf_pkg::cmd_type    cmd
);
   import akf_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0] state_ff, state_in;
   op_type     op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               op_in       = OP_PRED_ANGLE;
               state_in    = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.done) begin
               cmd.wb = 1'b1;
               if (op_ff == OP_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_OUT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // Output register valid: set on load, drop on transfer
   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PRED_ANGLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   // An accepted item keeps the input stalled on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after transfer");

   // A unit only finishes while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (state_ff == ST_WAIT))
      else $error("unit finished outside wait state");

   // A new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");
`endif

endmodule

// ----- rtl/angle_gyro_kalman_filter.sv -----
// Top level of the two-state (angle, gyro bias) Kalman filter.
//
//   channel  direction  handshake        payload
//   req      in         req_valid/stall  req_angle_meas, req_gyro_rate
//   rsp      out        rsp_valid/stall  rsp_angle_estimate
//   csr      in         csr_write_enable csr_index, csr_write_data
//
// The bit-serial divider for the two gains dominates; the ten products share
// one multiplier that takes 16 bits of an operand per cycle.
// Reset is synchronous: covariance to identity, angle and bias cleared.
// A finished result waits in the output register while the next item runs.
module angle_gyro_kalman_filter #(
   parameter int unsigned DATA_WIDTH    = 32,
   parameter int unsigned COV_FRAC_BITS = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [DATA_WIDTH-1:0]        req_angle_meas,
   input  logic signed [DATA_WIDTH-1:0]        req_gyro_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [DATA_WIDTH-1:0]        rsp_angle_estimate,
   input  logic                                csr_write_enable,
   input  logic [akf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [akf_pkg::REG_WIDTH-1:0]       csr_write_data
);
   import akf_pkg::*;

   cmd_type    cmd;
   status_type status;

   akf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   akf_datapath #(.W(DATA_WIDTH), .F(COV_FRAC_BITS)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_angle_meas     (req_angle_meas),
      .req_gyro_rate      (req_gyro_rate),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_angle_estimate (rsp_angle_estimate)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the angle/gyro-bias Kalman filter.
module tb_top;
   import akf_pkg::*;

   localparam longint SMAX = 64'sd2147483647;
   localparam longint SMIN = -64'sd2147483648;
   localparam int SETTLE = 300;
   localparam int LIMIT = 4000000;
   localparam logic [REG_WIDTH-1:0] REG_MAX = '1;

   typedef struct {
      logic signed [31:0] meas;
      logic signed [31:0] gyro;
      bit                 known;
      logic signed [31:0] value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_angle_meas = '0;
   logic signed [31:0] req_gyro_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_angle_estimate;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0] csr_write_data = '0;

   // Filter model state and register copies
   longint m_angle, m_bias, m_paa, m_pab, m_pba, m_pbb;
   longint r_dt, r_qa, r_qb, r_rn;

   logic signed [31:0] estimate_q[$];
   int errors = 0;
   int items_sent = 0;
   int estimates_seen = 0;
   int zero_gain_steps = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   angle_gyro_kalman_filter dut (.*);

   always #6 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d estimates pending", cycles, estimate_q.size());
         $display("[angle_gyro_kalman_filter] ERROR");
         $finish;
      end
   end

   task automatic report(string what, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      $display("mismatch %s: expected %0d got %0d (estimate %0d)", what, want, got,
               estimates_seen);
   endtask

   function automatic longint sat32(longint x);
      if (x > SMAX) return SMAX;
      if (x < SMIN) return SMIN;
      return x;
   endfunction

   // Q2.30 product, rounded to nearest with ties away from zero, capped at 2^62
   function automatic longint mul_round(longint a, longint b);
      bit neg;
      logic [63:0] ua, ub;
      logic [127:0] p, q;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 64'(-a) : 64'(a);
      ub = b < 0 ? 64'(-b) : 64'(b);
      p = {64'd0, ua} * {64'd0, ub};
      q = (p + (128'd1 << 29)) >> 30;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   // Q2.30 quotient n/d for d > 0, rounded and saturated
   function automatic longint div_round(longint n, longint d);
      logic [63:0] un;
      logic [127:0] num, q, r;
      un = n < 0 ? 64'(-n) : 64'(n);
      num = {64'd0, un} << 30;
      q = num / d;
      r = num % d;
      if ((r << 1) >= d) q++;
      if (q > (128'd1 << 31)) q = 128'd1 << 31;
      return sat32(n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]));
   endfunction

   // Advance the filter model by one sample and return the new angle
   function automatic logic signed [31:0] predict_estimate(logic signed [31:0] meas,
                                                           logic signed [31:0] gyro);
      longint rate, t, dp, err, s, k0, k1, p00, p01;
      k0 = 0;
      k1 = 0;
      rate = sat32(longint'(gyro) - m_bias);
      m_angle = sat32(m_angle + mul_round(rate, r_dt));
      t = mul_round(r_dt, m_pbb) - m_pab - m_pba + r_qa;
      m_paa = sat32(m_paa + mul_round(r_dt, t));
      dp = mul_round(r_dt, m_pbb);
      m_pab = sat32(m_pab - dp);
      m_pba = sat32(m_pba - dp);
      m_pbb = sat32(m_pbb + mul_round(r_qb, r_dt));
      err = longint'(meas) - m_angle;
      s = m_paa + r_rn;
      if (s > 0) begin
         k0 = div_round(m_paa, s);
         k1 = div_round(m_pba, s);
      end else begin
         zero_gain_steps++;
      end
      m_angle = sat32(m_angle + mul_round(k0, err));
      m_bias = sat32(m_bias + mul_round(k1, err));
      p00 = m_paa;
      p01 = m_pab;
      m_paa = sat32(m_paa - mul_round(k0, p00));
      m_pab = sat32(m_pab - mul_round(k0, p01));
      m_pba = sat32(m_pba - mul_round(k1, p00));
      m_pbb = sat32(m_pbb - mul_round(k1, p01));
      return m_angle[31:0];
   endfunction

   // Present one sample, hold it until the transfer, then queue its estimate
   task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                              bit known, logic signed [31:0] value);
      logic signed [31:0] est;
      while (!quiet && $urandom_range(99) < 16) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_angle_meas = meas;
      req_gyro_rate = gyro;
      do @(posedge clock); while (req_stall);
      est = predict_estimate(meas, gyro);
      estimate_q.push_back(known ? value : est);
      items_sent++;
      @(negedge clock);
   endtask

   // Drain all estimates, then let the block settle before touching registers
   task automatic wait_idle();
      req_valid = 1'b0;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [REG_WIDTH-1:0] data);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_SAMPLE_PERIOD: r_dt = data;
         CSR_ANGLE_NOISE:   r_qa = data;
         CSR_BIAS_NOISE:    r_qb = data;
         default:           r_rn = data;
      endcase
   endtask

   function automatic logic signed [31:0] rand_field();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return $signed(32'($urandom_range(0, 180 << 16))) - (90 <<< 16);
      if (pick < 85) return $urandom;
      if (pick < 93) return 32'h7FFF_FFFF;
      return 32'h8000_0000;
   endfunction

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_stall = !quiet && ($urandom_range(99) < 16);
   end

   // Compare each transferred estimate with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (estimate_q.size() == 0) begin
            report("unexpected estimate", 0, rsp_angle_estimate);
         end else begin
            logic signed [31:0] want;
            want = estimate_q.pop_front();
            if (rsp_angle_estimate !== want) report("angle_estimate", want, rsp_angle_estimate);
         end
         estimates_seen++;
      end
   end

   stim_row_type directed[] = '{
      '{32'sd0,          32'sd0,          1'b1, 32'sd0},
      '{32'h7FFF_FFFF,   32'sd0,          1'b0, 32'sd0},
      '{32'h8000_0000,   32'sd0,          1'b0, 32'sd0},
      '{32'sd0,          32'h7FFF_FFFF,   1'b0, 32'sd0},
      '{32'sd0,          32'h8000_0000,   1'b0, 32'sd0},
      '{32'h7FFF_FFFF,   32'h7FFF_FFFF,   1'b0, 32'sd0},
      '{32'h8000_0000,   32'h8000_0000,   1'b0, 32'sd0},
      '{32'h5555_5555,   32'hAAAA_AAAA,   1'b0, 32'sd0},
      '{32'hAAAA_AAAA,   32'h5555_5555,   1'b0, 32'sd0},
      '{32'sd65536,      32'sd655360,     1'b0, 32'sd0},
      '{-32'sd65536,     -32'sd655360,    1'b0, 32'sd0},
      '{32'sd1,          -32'sd1,         1'b0, 32'sd0},
      '{32'sd2949120,    32'sd0,          1'b0, 32'sd0},
      '{-32'sd2949120,   32'sd32768,      1'b0, 32'sd0}
   };

   initial begin
      int phase;
      m_angle = 0; m_bias = 0; m_pab = 0; m_pba = 0;
      m_paa = 64'sd1 << 30; m_pbb = 64'sd1 << 30;
      r_dt = RST_SAMPLE_PERIOD; r_qa = RST_ANGLE_NOISE;
      r_qb = RST_BIAS_NOISE; r_rn = RST_MEASURE_NOISE;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples under reset settings
      foreach (directed[i])
         send_sample(directed[i].meas, directed[i].gyro, directed[i].known, directed[i].value);

      // Random phases, each under its own register setting
      for (phase = 0; phase < 6; phase++) begin
         wait_idle();
         quiet = (phase == 5);
         case (phase)
            0: begin
               write_reg(CSR_SAMPLE_PERIOD, RST_SAMPLE_PERIOD);
               write_reg(CSR_ANGLE_NOISE, RST_ANGLE_NOISE);
               write_reg(CSR_BIAS_NOISE, RST_BIAS_NOISE);
               write_reg(CSR_MEASURE_NOISE, RST_MEASURE_NOISE);
            end
            1: begin
               // zero period and zero noise: innovation can reach zero
               write_reg(CSR_SAMPLE_PERIOD, '0);
               write_reg(CSR_ANGLE_NOISE, '0);
               write_reg(CSR_BIAS_NOISE, '0);
               write_reg(CSR_MEASURE_NOISE, '0);
            end
            2: begin
               write_reg(CSR_SAMPLE_PERIOD, REG_MAX);
               write_reg(CSR_ANGLE_NOISE, REG_MAX);
               write_reg(CSR_BIAS_NOISE, REG_MAX);
               write_reg(CSR_MEASURE_NOISE, REG_MAX);
            end
            3: begin
               write_reg(CSR_SAMPLE_PERIOD, REG_WIDTH'($urandom));
               write_reg(CSR_ANGLE_NOISE, REG_WIDTH'($urandom));
               write_reg(CSR_BIAS_NOISE, REG_WIDTH'($urandom));
               write_reg(CSR_MEASURE_NOISE, REG_WIDTH'($urandom_range(1, 32'h7FFF_FFFF)));
            end
            default: begin
               write_reg(CSR_SAMPLE_PERIOD, REG_WIDTH'($urandom_range(1, 1 << 25)));
               write_reg(CSR_ANGLE_NOISE, REG_WIDTH'($urandom_range(0, 1 << 24)));
               write_reg(CSR_BIAS_NOISE, REG_WIDTH'($urandom_range(0, 1 << 24)));
               write_reg(CSR_MEASURE_NOISE, REG_WIDTH'($urandom_range(1 << 20, 1 << 30)));
            end
         endcase
         repeat (175) send_sample(rand_field(), rand_field(), 1'b0, 32'sd0);
      end

      // Drain and settle before the verdict
      wait_idle();
      $display("sent %0d samples over 7 register settings, checked %0d estimates",
               items_sent, estimates_seen);
      $display("%0d steps ran with a non-positive innovation, %0d mismatches",
               zero_gain_steps, errors);
      if (errors == 0 && estimate_q.size() == 0) begin
         $display("[angle_gyro_kalman_filter] OK");
      end else begin
         $display("[angle_gyro_kalman_filter] ERROR");
      end
      $finish;
   end
endmodule
